@@ rtl/tsp_pkg.sv @@
`default_nettype none

package tsp_pkg;

  // Default widths
  localparam int SAMPLE_BITS_DEF   = 10;
  localparam int FRACTION_BITS_DEF = 8;

  // Screen resolution and position width
  localparam int RES_BITS     = 12;
  localparam int CFG_IDX_BITS = 3;

  // Register reset values
  localparam int X_LOW_RST     = 50;
  localparam int X_HIGH_RST    = 930;
  localparam int Y_LOW_RST     = 50;
  localparam int Y_HIGH_RST    = 930;
  localparam int SWAP_RST      = 3;
  localparam int THRESH_RST    = 50;
  localparam int WIDTH_RST     = 640;
  localparam int HEIGHT_RST    = 480;

  // Register map
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_X_LOW,
    CFG_X_HIGH,
    CFG_Y_LOW,
    CFG_Y_HIGH,
    CFG_AXIS_SWAP,
    CFG_PRESS_THRESH,
    CFG_SCREEN_W,
    CFG_SCREEN_H
  } cfg_reg_t;

  // Event codes on the result channel
  typedef enum logic [1:0] {
    EV_X_MOTION,
    EV_Y_MOTION,
    EV_PRESS,
    EV_RELEASE
  } event_kind_t;

  // Top level sequencer
  typedef enum logic [2:0] {
    TS_IDLE,
    TS_X_GO,
    TS_X_WAIT,
    TS_Y_GO,
    TS_Y_WAIT,
    TS_DECIDE,
    TS_EMIT
  } top_state_t;

  // Axis scaler sequencer
  typedef enum logic [2:0] {
    AX_IDLE,
    AX_DIV_GO,
    AX_DIV_WAIT,
    AX_MUL,
    AX_OUT
  } axis_state_t;

  // Request from the top sequencer to the axis scaler
  typedef struct packed {
    logic start;
    logic mirror;
  } scale_req_t;

endpackage

`default_nettype wire

@@ rtl/tsp_divider.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend must not
// exceed the divisor; the quotient is dividend * 2^(QUO_BITS-1) / divisor.
module tsp_divider #(
  parameter int DEN_BITS = tsp_pkg::SAMPLE_BITS_DEF,
  parameter int QUO_BITS = tsp_pkg::FRACTION_BITS_DEF + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DEN_BITS-1:0] dividend,
  input  logic [DEN_BITS-1:0] divisor,
  output logic [QUO_BITS-1:0] quotient,
  output logic                done
);

  localparam int CNT_BITS = $clog2(QUO_BITS + 1);

  logic [DEN_BITS:0]   rem_r, rem_nxt;
  logic [DEN_BITS-1:0] den_r;
  logic [QUO_BITS-1:0] quo_r, quo_nxt;
  logic [CNT_BITS-1:0] cnt_r;
  logic                first_r;
  logic                busy_r;
  logic                done_r;

  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;
  logic                ge;

  // Shift-subtract step; the first step takes the integer bit unshifted
  always_comb begin
    trial   = first_r ? rem_r : {rem_r[DEN_BITS-1:0], 1'b0};
    diff    = trial - {1'b0, den_r};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? diff : trial;
    quo_nxt = {quo_r[QUO_BITS-2:0], ge};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(QUO_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r   <= {1'b0, dividend};
      den_r   <= divisor;
      quo_r   <= '0;
      first_r <= 1'b1;
    end else if (busy_r) begin
      rem_r   <= rem_nxt;
      quo_r   <= quo_nxt;
      first_r <= 1'b0;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

@@ rtl/tsp_axis_scale.sv @@
`default_nettype none

// Clips one raw reading to its window, scales it to screen resolution
// through the shared divider and a single multiply, and optionally mirrors it.
module tsp_axis_scale #(
  parameter int SAMPLE_BITS   = tsp_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = tsp_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tsp_pkg::scale_req_t           req,
  input  logic [SAMPLE_BITS-1:0]        sample,
  input  logic [SAMPLE_BITS-1:0]        win_low,
  input  logic [SAMPLE_BITS-1:0]        win_high,
  input  logic [tsp_pkg::RES_BITS-1:0]  res,
  output logic [tsp_pkg::RES_BITS-1:0]  pos,
  output logic                          done
);

  localparam int RB        = tsp_pkg::RES_BITS;
  localparam int QUO_BITS  = FRACTION_BITS + 1;
  localparam int PROD_BITS = QUO_BITS + RB;

  tsp_pkg::axis_state_t state_r, state_nxt;

  logic [SAMPLE_BITS-1:0] num_r;
  logic [SAMPLE_BITS-1:0] den_r;
  logic                   empty_r;
  logic                   mirror_r;
  logic [RB-1:0]          res_r;
  logic [PROD_BITS-1:0]   prod_r;
  logic [RB-1:0]          pos_r, pos_nxt;
  logic                   done_r;

  logic [SAMPLE_BITS-1:0] clip_hi;
  logic [SAMPLE_BITS-1:0] clip;
  logic                   span_ok;
  logic                   div_start;
  logic                   div_done;
  logic [QUO_BITS-1:0]    quotient;
  logic [RB-1:0]          scaled;

  // Window clip: high bound first, then low
  always_comb begin
    clip_hi = (sample > win_high) ? win_high : sample;
    clip    = (clip_hi < win_low) ? win_low : clip_hi;
    span_ok = win_high > win_low;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsp_pkg::AX_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == tsp_pkg::AX_OUT);
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    case (state_r)
      tsp_pkg::AX_IDLE: begin
        if (req.start) begin
          state_nxt = span_ok ? tsp_pkg::AX_DIV_GO : tsp_pkg::AX_OUT;
        end
      end
      tsp_pkg::AX_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = tsp_pkg::AX_DIV_WAIT;
      end
      tsp_pkg::AX_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = tsp_pkg::AX_MUL;
        end
      end
      tsp_pkg::AX_MUL: begin
        state_nxt = tsp_pkg::AX_OUT;
      end
      tsp_pkg::AX_OUT: begin
        state_nxt = tsp_pkg::AX_IDLE;
      end
      default: begin
        state_nxt = tsp_pkg::AX_IDLE;
      end
    endcase
  end

  // Shared divider
  tsp_divider #(
    .DEN_BITS (SAMPLE_BITS),
    .QUO_BITS (QUO_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_r),
    .divisor  (den_r),
    .quotient (quotient),
    .done     (div_done)
  );

  // Drop the fraction, then mirror; an empty window scales to 0 before the mirror
  always_comb begin
    scaled  = empty_r ? '0 : prod_r[FRACTION_BITS +: RB];
    pos_nxt = mirror_r ? (res_r - scaled) : scaled;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state_r == tsp_pkg::AX_IDLE && req.start) begin
      num_r    <= clip - win_low;
      den_r    <= win_high - win_low;
      empty_r  <= !span_ok;
      mirror_r <= req.mirror;
      res_r    <= res;
    end
    if (state_r == tsp_pkg::AX_MUL) begin
      prod_r <= PROD_BITS'(quotient) * PROD_BITS'(res_r);
    end
    if (state_r == tsp_pkg::AX_OUT) begin
      pos_r <= pos_nxt;
    end
  end

  assign pos  = pos_r;
  assign done = done_r;

endmodule

`default_nettype wire

@@ rtl/touch_sample_to_pointer_events_unit.sv @@
`default_nettype none

// Turns one raw touch sample (X, Y, pressure) into zero to three pointer
// events: X motion, Y motion, then press or release, the final one flagged
// by out_last_event. Each axis is clipped to its calibration window, scaled
// to the screen in FRACTION_BITS fixed point and optionally mirrored; motion
// is reported only while touched and only when the position changed. One
// sample is handled at a time and in_ready is low until its last event has
// been taken. The first event waits until the single restoring divider, which
// resolves one quotient bit per cycle and serves both axes in turn, has
// scaled both; then each event takes one beat, which out_ready can hold off.
// Configuration writes are always accepted and must only be made while the
// block is idle.
module touch_sample_to_pointer_events_unit #(
  parameter int SAMPLE_BITS   = tsp_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = tsp_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [SAMPLE_BITS-1:0]            in_sample_x,
  input  logic [SAMPLE_BITS-1:0]            in_sample_y,
  input  logic [SAMPLE_BITS-1:0]            in_sample_pressure,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_event_kind,
  output logic [tsp_pkg::RES_BITS-1:0]      out_position,
  output logic                              out_last_event,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tsp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [((SAMPLE_BITS > tsp_pkg::RES_BITS) ? SAMPLE_BITS
                 : tsp_pkg::RES_BITS)-1:0]  cfg_data
);

  localparam int RB = tsp_pkg::RES_BITS;

  // Configuration registers
  logic [SAMPLE_BITS-1:0] x_low_r, x_high_r, y_low_r, y_high_r, thresh_r;
  logic [1:0]             swap_r;
  logic [RB-1:0]          width_r, height_r;

  // Sample and results
  logic [SAMPLE_BITS-1:0] samp_x_r, samp_y_r;
  logic                   touched_r;
  logic [RB-1:0]          px_r, py_r;

  // Stored pointer state
  logic [RB-1:0]          prev_x_r, prev_y_r;
  logic                   prev_x_vld_r, prev_y_vld_r;
  logic                   prev_touch_r;

  // Pending events of the current sample
  logic                   need_x_r, need_y_r, need_btn_r;
  logic                   need_x_nxt, need_y_nxt, need_btn_nxt;

  tsp_pkg::top_state_t    state_r, state_nxt;

  tsp_pkg::scale_req_t    sc_req;
  logic [SAMPLE_BITS-1:0] sc_sample, sc_low, sc_high;
  logic [RB-1:0]          sc_res;
  logic [RB-1:0]          sc_pos;
  logic                   sc_done;

  logic                   in_beat;
  logic                   out_beat;
  logic                   last_ev;
  tsp_pkg::event_kind_t   ev_kind;

  assign in_ready  = (state_r == tsp_pkg::TS_IDLE);
  assign cfg_ready = 1'b1;
  assign in_beat   = in_valid && in_ready;
  assign out_beat  = out_valid && out_ready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_low_r  <= SAMPLE_BITS'(tsp_pkg::X_LOW_RST);
      x_high_r <= SAMPLE_BITS'(tsp_pkg::X_HIGH_RST);
      y_low_r  <= SAMPLE_BITS'(tsp_pkg::Y_LOW_RST);
      y_high_r <= SAMPLE_BITS'(tsp_pkg::Y_HIGH_RST);
      swap_r   <= 2'(tsp_pkg::SWAP_RST);
      thresh_r <= SAMPLE_BITS'(tsp_pkg::THRESH_RST);
      width_r  <= RB'(tsp_pkg::WIDTH_RST);
      height_r <= RB'(tsp_pkg::HEIGHT_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (tsp_pkg::cfg_reg_t'(cfg_index))
        tsp_pkg::CFG_X_LOW:        x_low_r  <= cfg_data[SAMPLE_BITS-1:0];
        tsp_pkg::CFG_X_HIGH:       x_high_r <= cfg_data[SAMPLE_BITS-1:0];
        tsp_pkg::CFG_Y_LOW:        y_low_r  <= cfg_data[SAMPLE_BITS-1:0];
        tsp_pkg::CFG_Y_HIGH:       y_high_r <= cfg_data[SAMPLE_BITS-1:0];
        tsp_pkg::CFG_AXIS_SWAP:    swap_r   <= cfg_data[1:0];
        tsp_pkg::CFG_PRESS_THRESH: thresh_r <= cfg_data[SAMPLE_BITS-1:0];
        tsp_pkg::CFG_SCREEN_W:     width_r  <= cfg_data[RB-1:0];
        tsp_pkg::CFG_SCREEN_H:     height_r <= cfg_data[RB-1:0];
        default: ;
      endcase
    end
  end

  // Axis scaler request: X first, then Y
  always_comb begin
    sc_req.start  = (state_r == tsp_pkg::TS_X_GO) || (state_r == tsp_pkg::TS_Y_GO);
    if (state_r == tsp_pkg::TS_Y_GO) begin
      sc_req.mirror = swap_r[1];
      sc_sample     = samp_y_r;
      sc_low        = y_low_r;
      sc_high       = y_high_r;
      sc_res        = height_r;
    end else begin
      sc_req.mirror = swap_r[0];
      sc_sample     = samp_x_r;
      sc_low        = x_low_r;
      sc_high       = x_high_r;
      sc_res        = width_r;
    end
  end

  tsp_axis_scale #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_axis (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (sc_req),
    .sample   (sc_sample),
    .win_low  (sc_low),
    .win_high (sc_high),
    .res      (sc_res),
    .pos      (sc_pos),
    .done     (sc_done)
  );

  // Event selection: X, then Y, then the button edge
  always_comb begin
    last_ev = ({1'b0, need_x_r} + {1'b0, need_y_r} + {1'b0, need_btn_r}) == 2'd1;
    if (need_x_r) begin
      ev_kind      = tsp_pkg::EV_X_MOTION;
      out_position = px_r;
    end else if (need_y_r) begin
      ev_kind      = tsp_pkg::EV_Y_MOTION;
      out_position = py_r;
    end else begin
      ev_kind      = touched_r ? tsp_pkg::EV_PRESS : tsp_pkg::EV_RELEASE;
      out_position = '0;
    end
  end

  assign out_valid      = (state_r == tsp_pkg::TS_EMIT);
  assign out_event_kind = ev_kind;
  assign out_last_event = last_ev;

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    need_x_nxt   = need_x_r;
    need_y_nxt   = need_y_r;
    need_btn_nxt = need_btn_r;
    case (state_r)
      tsp_pkg::TS_IDLE: begin
        if (in_beat) begin
          state_nxt = tsp_pkg::TS_X_GO;
        end
      end
      tsp_pkg::TS_X_GO: begin
        state_nxt = tsp_pkg::TS_X_WAIT;
      end
      tsp_pkg::TS_X_WAIT: begin
        if (sc_done) begin
          state_nxt = tsp_pkg::TS_Y_GO;
        end
      end
      tsp_pkg::TS_Y_GO: begin
        state_nxt = tsp_pkg::TS_Y_WAIT;
      end
      tsp_pkg::TS_Y_WAIT: begin
        if (sc_done) begin
          state_nxt = tsp_pkg::TS_DECIDE;
        end
      end
      tsp_pkg::TS_DECIDE: begin
        need_x_nxt   = touched_r && (!prev_x_vld_r || px_r != prev_x_r);
        need_y_nxt   = touched_r && (!prev_y_vld_r || py_r != prev_y_r);
        need_btn_nxt = touched_r != prev_touch_r;
        state_nxt    = (need_x_nxt || need_y_nxt || need_btn_nxt) ?
                       tsp_pkg::TS_EMIT : tsp_pkg::TS_IDLE;
      end
      tsp_pkg::TS_EMIT: begin
        if (out_beat) begin
          if (need_x_r) begin
            need_x_nxt = 1'b0;
          end else if (need_y_r) begin
            need_y_nxt = 1'b0;
          end else begin
            need_btn_nxt = 1'b0;
          end
          if (last_ev) begin
            state_nxt = tsp_pkg::TS_IDLE;
          end
        end
      end
      default: begin
        state_nxt = tsp_pkg::TS_IDLE;
      end
    endcase
  end

  // Control state and stored pointer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tsp_pkg::TS_IDLE;
      need_x_r     <= 1'b0;
      need_y_r     <= 1'b0;
      need_btn_r   <= 1'b0;
      prev_x_vld_r <= 1'b0;
      prev_y_vld_r <= 1'b0;
      prev_touch_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      need_x_r   <= need_x_nxt;
      need_y_r   <= need_y_nxt;
      need_btn_r <= need_btn_nxt;
      if (state_r == tsp_pkg::TS_DECIDE) begin
        prev_touch_r <= touched_r;
        if (need_x_nxt) begin
          prev_x_vld_r <= 1'b1;
        end
        if (need_y_nxt) begin
          prev_y_vld_r <= 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      samp_x_r  <= in_sample_x;
      samp_y_r  <= in_sample_y;
      touched_r <= in_sample_pressure > thresh_r;
    end
    if (state_r == tsp_pkg::TS_X_WAIT && sc_done) begin
      px_r <= sc_pos;
    end
    if (state_r == tsp_pkg::TS_Y_WAIT && sc_done) begin
      py_r <= sc_pos;
    end
    if (state_r == tsp_pkg::TS_DECIDE) begin
      if (need_x_nxt) begin
        prev_x_r <= px_r;
      end
      if (need_y_nxt) begin
        prev_y_r <= py_r;
      end
    end
  end

`ifndef SYNTH
  // Never taking a sample while events are still being delivered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while events pending");

  // The final event returns the block to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_event |=> in_ready)
    else $error("not idle after final event");

  // Button events carry no position
  a_btn_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == tsp_pkg::EV_PRESS ||
                  out_event_kind == tsp_pkg::EV_RELEASE) |-> out_position == '0)
    else $error("button event with non-zero position");

  // Scaler results only arrive while the sequencer waits for them
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sc_done |-> (state_r == tsp_pkg::TS_X_WAIT || state_r == tsp_pkg::TS_Y_WAIT))
    else $error("axis result outside wait state");
`endif

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import tsp_pkg::*;

  localparam int STALL_LIMIT = 3000;  // cycles with no beat on any channel
  localparam int DRAIN_CYCLES = 60;   // lets a sample with no events finish
  localparam int HOLD_CYCLES = 400;

  // Predicts the pointer events of each accepted touch sample and checks
  // the events the block delivers against them, oldest first.
  class pointer_scoreboard;
    typedef struct packed {
      event_kind_t kind;
      logic [11:0] pos;
      logic        last;
    } ptr_event_t;

    ptr_event_t  due[$];
    int          errors;
    logic [9:0]  x_lo, x_hi, y_lo, y_hi, thresh;
    logic [1:0]  swap;
    logic [11:0] width, height;
    logic [15:0] last_x, last_y;
    logic        touching;

    function new();
      x_lo     = 10'(X_LOW_RST);
      x_hi     = 10'(X_HIGH_RST);
      y_lo     = 10'(Y_LOW_RST);
      y_hi     = 10'(Y_HIGH_RST);
      swap     = 2'(SWAP_RST);
      thresh   = 10'(THRESH_RST);
      width    = 12'(WIDTH_RST);
      height   = 12'(HEIGHT_RST);
      last_x   = 16'hFFFF;
      last_y   = 16'hFFFF;
      touching = 1'b0;
      errors   = 0;
    endfunction

    // Register writes are masked to the register width
    function void set_reg(cfg_reg_t idx, logic [11:0] d);
      case (idx)
        CFG_X_LOW:        x_lo = d[9:0];
        CFG_X_HIGH:       x_hi = d[9:0];
        CFG_Y_LOW:        y_lo = d[9:0];
        CFG_Y_HIGH:       y_hi = d[9:0];
        CFG_AXIS_SWAP:    swap = d[1:0];
        CFG_PRESS_THRESH: thresh = d[9:0];
        CFG_SCREEN_W:     width = d;
        CFG_SCREEN_H:     height = d;
        default: ;
      endcase
    endfunction

    // Clip to window (high first), scale in fixed point, optionally mirror
    function logic [11:0] map_to_screen(logic [9:0] raw, logic [9:0] lo,
                                        logic [9:0] hi, logic [11:0] res,
                                        logic mirror);
      int unsigned v, q, s, lo_u, hi_u, res_u;
      v     = {22'd0, raw};
      lo_u  = {22'd0, lo};
      hi_u  = {22'd0, hi};
      res_u = {20'd0, res};
      if (v > hi_u) v = hi_u;
      if (v < lo_u) v = lo_u;
      q = 0;
      s = 0;
      if (hi_u > lo_u) begin
        q = ((v - lo_u) << FRACTION_BITS_DEF) / (hi_u - lo_u);
        s = (q * res_u) >> FRACTION_BITS_DEF;
      end
      if (s > res_u) s = res_u;
      if (mirror) s = res_u - s;
      return 12'(s);
    endfunction

    function void note_sample(logic [9:0] sx, logic [9:0] sy, logic [9:0] sp);
      ptr_event_t  ev [3];
      logic [11:0] px, py;
      logic        touched;
      int          n;
      px      = map_to_screen(sx, x_lo, x_hi, width, swap[0]);
      py      = map_to_screen(sy, y_lo, y_hi, height, swap[1]);
      touched = sp > thresh;
      n       = 0;
      // motion only while touched, and only on a changed position
      if (touched) begin
        if ({4'h0, px} != last_x) begin
          ev[n] = '{kind: EV_X_MOTION, pos: px, last: 1'b0};
          n++;
          last_x = {4'h0, px};
        end
        if ({4'h0, py} != last_y) begin
          ev[n] = '{kind: EV_Y_MOTION, pos: py, last: 1'b0};
          n++;
          last_y = {4'h0, py};
        end
      end
      // press or release on a touch edge
      if (touched != touching) begin
        ev[n] = '{kind: touched ? EV_PRESS : EV_RELEASE, pos: 12'h000, last: 1'b0};
        n++;
        touching = touched;
      end
      for (int i = 0; i < n; i++) begin
        if (i == n - 1) ev[i].last = 1'b1;
        due.push_back(ev[i]);
      end
    endfunction

    function void check_event(logic [1:0] kind, logic [11:0] pos, logic last);
      ptr_event_t e;
      if (due.size() == 0) begin
        $display("%0t: unexpected event: kind %0d position %0d last %0b",
                 $time, kind, pos, last);
        errors++;
        return;
      end
      e = due.pop_front();
      if (kind !== e.kind) begin
        $display("%0t: event_kind mismatch: expected %0d, actual %0d",
                 $time, e.kind, kind);
        errors++;
      end
      if (pos !== e.pos) begin
        $display("%0t: position mismatch: expected %0d, actual %0d",
                 $time, e.pos, pos);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last_event mismatch: expected %0b, actual %0b",
                 $time, e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [9:0]  in_sample_x;
  logic [9:0]  in_sample_y;
  logic [9:0]  in_sample_pressure;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_event_kind;
  logic [11:0] out_position;
  logic        out_last_event;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [11:0] cfg_data;

  pointer_scoreboard sb;
  bit steady;    // no idling on either side
  bit hold_req;  // asks the receiver for a long hold-off
  int idle_cycles;

  touch_sample_to_pointer_events_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample_x        (in_sample_x),
    .in_sample_y        (in_sample_y),
    .in_sample_pressure (in_sample_pressure),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_kind     (out_event_kind),
    .out_position       (out_position),
    .out_last_event     (out_last_event),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_event(out_event_kind, out_position, out_last_event);
    end
  end

  // Watchdog: cycles without a beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, or a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (steady) begin
        out_ready = 1'b1;
      end else begin
        out_ready = ($urandom_range(0, 99) >= 33);
      end
    end
  end

  // Offer one sample, with an occasional gap first; valid stays high after the beat
  task automatic send_sample(input logic [9:0] sx, input logic [9:0] sy,
                             input logic [9:0] sp);
    int gap;
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < 33) begin
      gap      = $urandom_range(1, 45);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           = 1'b1;
    in_sample_x        = sx;
    in_sample_y        = sy;
    in_sample_pressure = sp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(sx, sy, sp);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [11:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drain all events, then let a sample with no events finish too
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random register set; junk in the upper data bits checks the masking
  task automatic pick_setup();
    logic [9:0] lo, hi;
    logic [1:0] pad;
    for (int ax = 0; ax < 2; ax++) begin
      lo  = 10'($urandom_range(0, 400));
      hi  = ($urandom_range(0, 5) == 0) ? 10'($urandom_range(0, lo))
                                        : 10'($urandom_range(lo + 1, 1023));
      pad = 2'($urandom_range(0, 3));
      write_reg(ax ? CFG_Y_LOW : CFG_X_LOW, {pad, lo});
      pad = 2'($urandom_range(0, 3));
      write_reg(ax ? CFG_Y_HIGH : CFG_X_HIGH, {pad, hi});
      case ($urandom_range(0, 3))
        0:       write_reg(ax ? CFG_SCREEN_H : CFG_SCREEN_W, 12'hFFF);
        1:       write_reg(ax ? CFG_SCREEN_H : CFG_SCREEN_W, 12'($urandom_range(1, 16)));
        default: write_reg(ax ? CFG_SCREEN_H : CFG_SCREEN_W, 12'($urandom_range(1, 4095)));
      endcase
    end
    write_reg(CFG_AXIS_SWAP, 12'($urandom));
    pad = 2'($urandom_range(0, 3));
    write_reg(CFG_PRESS_THRESH, ($urandom_range(0, 4) == 0) ? {pad, 10'h000}
                                : {pad, 10'($urandom_range(0, 700))});
  endtask

  // Keep, jump or nudge a raw coordinate
  function automatic logic [9:0] wander(logic [9:0] v);
    int w;
    case ($urandom_range(0, 2))
      0: return v;
      1: return 10'($urandom_range(0, 1023));
      default: begin
        w = int'(v) + int'($urandom_range(0, 6)) - 3;
        if (w < 0) w = 0;
        if (w > 1023) w = 1023;
        return 10'(w);
      end
    endcase
  endfunction

  // Strokes: touched samples that wander, then a lift; some noise samples
  task automatic run_strokes(input int n_items, input int hold_at);
    int         sent, len, lifts;
    logic [9:0] sx, sy, sp;
    sent = 0;
    sx   = 10'($urandom_range(0, 1023));
    sy   = 10'($urandom_range(0, 1023));
    while (sent < n_items) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len && sent < n_items; i++) begin
        sx = wander(sx);
        sy = wander(sy);
        if (sb.thresh == 10'h3FF || $urandom_range(0, 9) == 0) begin
          sp = 10'($urandom_range(0, 1023));
        end else begin
          sp = 10'($urandom_range(sb.thresh + 1, 1023));
        end
        send_sample(sx, sy, sp);
        sent++;
        if (sent == hold_at) hold_req = 1'b1;
      end
      lifts = $urandom_range(1, 3);
      for (int i = 0; i < lifts && sent < n_items; i++) begin
        sp = 10'($urandom_range(0, sb.thresh));
        send_sample(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)), sp);
        sent++;
        if (sent == hold_at) hold_req = 1'b1;
      end
    end
  endtask

  initial begin
    sb                 = new();
    steady             = 1'b0;
    hold_req           = 1'b0;
    idle_cycles        = 0;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_sample_x        = '0;
    in_sample_y        = '0;
    in_sample_pressure = '0;
    cfg_valid          = 1'b0;
    cfg_index          = CFG_X_LOW;
    cfg_data           = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: clipping both ends, press, idle repeat, threshold edge
    send_sample(10'd0, 10'd0, 10'd0);
    send_sample(10'd0, 10'd0, 10'd1023);
    send_sample(10'd0, 10'd0, 10'd1023);
    send_sample(10'd1023, 10'd1023, 10'd1023);
    send_sample(10'd1023, 10'd1023, 10'd50);
    send_sample(10'd490, 10'd490, 10'd51);
    send_sample(10'd500, 10'd490, 10'd600);
    send_sample(10'd500, 10'd700, 10'd600);
    send_sample(10'd200, 10'd300, 10'd0);
    settle();

    // Full window, no mirroring, zero threshold, largest screen
    write_reg(CFG_X_LOW, 12'd0);
    write_reg(CFG_X_HIGH, 12'd1023);
    write_reg(CFG_Y_LOW, 12'd0);
    write_reg(CFG_Y_HIGH, 12'd1023);
    write_reg(CFG_AXIS_SWAP, 12'd0);
    write_reg(CFG_PRESS_THRESH, 12'd0);
    write_reg(CFG_SCREEN_W, 12'd4095);
    write_reg(CFG_SCREEN_H, 12'd4095);
    send_sample(10'd0, 10'd0, 10'd0);
    send_sample(10'd1023, 10'd1023, 10'd1);
    send_sample(10'd0, 10'd1023, 10'd1);
    send_sample(10'd512, 10'd512, 10'd1023);
    send_sample(10'd512, 10'd512, 10'd0);
    send_sample(10'd1023, 10'd0, 10'd0);
    settle();

    // Empty windows (equal and inverted), X mirrored, zero height,
    // oversized register data
    write_reg(CFG_X_LOW, 12'hE58);
    write_reg(CFG_X_HIGH, 12'd600);
    write_reg(CFG_Y_LOW, 12'd900);
    write_reg(CFG_Y_HIGH, 12'd100);
    write_reg(CFG_AXIS_SWAP, 12'hFFD);
    write_reg(CFG_PRESS_THRESH, 12'hDFF);
    write_reg(CFG_SCREEN_H, 12'd0);
    send_sample(10'd0, 10'd0, 10'd512);
    send_sample(10'd1023, 10'd1023, 10'd1023);
    send_sample(10'd600, 10'd100, 10'd511);
    send_sample(10'd777, 10'd5, 10'd1023);
    settle();

    // Top threshold: nothing counts as touched
    write_reg(CFG_PRESS_THRESH, 12'h3FF);
    send_sample(10'd300, 10'd300, 10'd1023);
    send_sample(10'd1023, 10'd0, 10'd1023);
    settle();

    // Random phases; the second runs without idling, the third holds
    // the receiver off mid-stroke
    for (int ph = 0; ph < 4; ph++) begin
      pick_setup();
      steady = (ph == 1);
      run_strokes(50, (ph == 2) ? 20 : -1);
      settle();
    end
    steady = 1'b0;

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
